// ===== hdl/lcogc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcogc_pkg
// Shared types and constants of the load-cell offset/gain calibrator: item
// and result payloads, item kinds, status codes, controller commands and
// datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package lcogc_pkg;

	// defaults
	localparam int          CHANNELS_DEF = 4;
	localparam logic [31:0] SCALE_RESET  = 32'd2147484;
	localparam logic [31:0] MULT_ONE     = 32'h0100_0000;

	// item kinds
	localparam logic [2:0] KIND_SAMPLE    = 3'd0;
	localparam logic [2:0] KIND_ZERO      = 3'd1;
	localparam logic [2:0] KIND_CAL       = 3'd2;
	localparam logic [2:0] KIND_SET_OFF   = 3'd3;
	localparam logic [2:0] KIND_SET_MULT  = 3'd4;
	localparam logic [2:0] KIND_RESET     = 3'd5;
	localparam logic [2:0] KIND_REPORT    = 3'd6;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_CAL = 2'd1;
	localparam logic [1:0] STATUS_SAT      = 2'd2;

	typedef struct packed {
		logic [2:0]         kind;
		logic [1:0]         channel;
		logic signed [23:0] raw_count;
		logic signed [31:0] operand_value;
	} lcogc_in_t;

	typedef struct packed {
		logic [1:0]         out_channel;
		logic signed [31:0] weight;
		logic signed [31:0] offset_now;
		logic signed [31:0] multiplier_now;
		logic [1:0]         status;
	} lcogc_out_t;

	// one strobe per datapath step
	typedef struct packed {
		logic take;
		logic fetch;
		logic mul_raw;
		logic rnd;
		logic sum_off;
		logic gain;
		logic wr_weight;
		logic wr_zero;
		logic mark_zero;
		logic cal_mul;
		logic div_start;
		logic wr_cal;
		logic wr_direct;
		logic commit;
	} lcogc_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       in_range;
		logic       w_zero;
		logic       div_busy;
		logic       out_free;
	} lcogc_sts_t;

endpackage

`default_nettype wire

// ===== hdl/lcogc_div.sv =====
// ----------------------------------------------------------------------------
// lcogc_div
// Restoring divider, one quotient bit per cycle. Computes
// (num + den/2) / den rounded to nearest; a quotient of 2^32 or more is
// flagged as overflow at start and takes no iterations.
// ----------------------------------------------------------------------------
`default_nettype none

module lcogc_div
	import lcogc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             busy,
	output logic             ovf,
	output logic [31:0]      quo
);

	localparam int QW = 32;

	logic [63:0]   dvd;
	logic [32:0]   trial;
	logic          fits;
	logic [31:0]   rem_q;
	logic [31:0]   lo_q;
	logic [31:0]   quo_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          ovf_q;

	// rounding bias and one trial subtraction
	always_comb begin
		dvd   = num + {33'd0, den[31:1]};
		trial = {rem_q, lo_q[31]};
		fits  = trial >= {1'b0, den};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			if (dvd[63:32] >= den) begin
				ovf_q  <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				ovf_q  <= 1'b0;
				busy_q <= 1'b1;
				cnt_q  <= 6'(QW);
			end
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != 6'd1);
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dvd[63:32];
			lo_q  <= dvd[31:0];
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign busy = busy_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/lcogc_datapath.sv =====
// ----------------------------------------------------------------------------
// lcogc_datapath
// Per-channel stores, scale register, multiply stages, saturation, the
// calibration divider and the result register. Every step runs on a
// command strobe from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lcogc_datapath
	import lcogc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire lcogc_in_t   in_data,
	input  wire lcogc_cmd_t  cmd,
	output lcogc_sts_t       sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output lcogc_out_t       out_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} sat_res_t;

	// clamp a magnitude with sign to the signed 32-bit range
	function automatic sat_res_t sat_mag(input logic [63:0] mag, input logic neg);
		sat_res_t r;
		if (!neg && mag > 64'h0000_0000_7FFF_FFFF) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else if (neg && mag > 64'h0000_0000_8000_0000) begin
			r.sat = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
		end
		return r;
	endfunction

	// configuration
	logic [31:0] scale_q;

	// item
	logic [2:0]         kind_q;
	logic [1:0]         ch_q;
	logic [CH_W-1:0]    idx_q;
	logic               inr_q;
	logic signed [23:0] raw_q;
	logic signed [31:0] opv_q;

	// stores
	logic signed [31:0] off_mem  [CHANNELS];
	logic signed [31:0] mul_mem  [CHANNELS];
	logic signed [23:0] lraw_mem [CHANNELS];
	logic signed [31:0] lw_mem   [CHANNELS];

	// fetched and updated channel values
	logic signed [31:0] cur_off_q, cur_mul_q, cur_lw_q;
	logic signed [23:0] cur_lraw_q;
	logic signed [31:0] new_off_q, new_mul_q, new_lw_q;
	logic signed [23:0] new_lraw_q;
	logic               sat_q;
	logic               zc_q;

	// arithmetic stages
	logic [55:0] p_q;
	logic        rneg_q;
	logic [39:0] r_q;
	logic        sneg_q;
	logic [40:0] smag_q;
	logic [48:0] ph_q;
	logic [55:0] pl_q;
	logic        gneg_q;
	logic [63:0] num_q;
	logic        cneg_q;

	// result register
	logic       out_valid_q;
	lcogc_out_t out_q;

	// divider
	logic        div_busy;
	logic        div_ovf;
	logic [31:0] div_quo;

	// combinational values
	logic [CH_W+1:0]    chx;
	logic signed [23:0] rsel;
	logic [23:0]        raw_mag;
	logic [55:0]        prod_raw;
	logic [39:0]        r_next;
	logic [41:0]        off_ext;
	logic [41:0]        s_sum;
	logic [41:0]        s_abs;
	logic [31:0]        mul_mag;
	logic [31:0]        opv_mag;
	logic [31:0]        lw_mag;
	logic [49:0]        w_mag;
	sat_res_t           w_sat;
	sat_res_t           z_sat;
	sat_res_t           c_sat;
	logic               out_free;

	// channel range check and index
	assign chx = {{CH_W{1'b0}}, in_data.channel};

	// operand selection and magnitudes
	always_comb begin
		rsel     = (kind_q == KIND_SAMPLE) ? raw_q : cur_lraw_q;
		raw_mag  = rsel[23] ? (24'd0 - rsel) : rsel;
		prod_raw = 56'(raw_mag) * 56'(scale_q);
		r_next   = 40'((p_q + 56'h8000) >> 16);
		off_ext  = {{10{cur_off_q[31]}}, cur_off_q};
		s_sum    = rneg_q ? (off_ext - {2'b00, r_q}) : (off_ext + {2'b00, r_q});
		s_abs    = s_sum[41] ? (42'd0 - s_sum) : s_sum;
		mul_mag  = cur_mul_q[31] ? (32'd0 - cur_mul_q) : cur_mul_q;
		opv_mag  = opv_q[31] ? (32'd0 - opv_q) : opv_q;
		lw_mag   = cur_lw_q[31] ? (32'd0 - cur_lw_q) : cur_lw_q;
		w_mag    = 50'(ph_q) + 50'((pl_q + 56'h80_0000) >> 24);
		w_sat    = sat_mag(64'(w_mag), gneg_q);
		z_sat    = sat_mag(64'(r_q), !rneg_q);
		c_sat    = div_ovf ? sat_mag({64{1'b1}}, cneg_q) : sat_mag(64'(div_quo), cneg_q);
		out_free = !out_valid_q || out_ready;
	end

	lcogc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (lw_mag),
		.busy   (div_busy),
		.ovf    (div_ovf),
		.quo    (div_quo)
	);

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// channel stores, written on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				off_mem[i]  <= '0;
				mul_mem[i]  <= MULT_ONE;
				lraw_mem[i] <= '0;
				lw_mem[i]   <= '0;
			end
		end else if (cmd.commit && inr_q) begin
			off_mem[idx_q]  <= new_off_q;
			mul_mem[idx_q]  <= new_mul_q;
			lraw_mem[idx_q] <= new_lraw_q;
			lw_mem[idx_q]   <= new_lw_q;
		end
	end

	// item capture and arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= in_data.kind;
			ch_q   <= in_data.channel;
			idx_q  <= chx[CH_W-1:0];
			inr_q  <= (chx < CHANNELS);
			raw_q  <= in_data.raw_count;
			opv_q  <= in_data.operand_value;
		end
		if (cmd.fetch) begin
			cur_off_q  <= off_mem[idx_q];
			cur_mul_q  <= mul_mem[idx_q];
			cur_lraw_q <= lraw_mem[idx_q];
			cur_lw_q   <= lw_mem[idx_q];
			new_off_q  <= off_mem[idx_q];
			new_mul_q  <= mul_mem[idx_q];
			new_lraw_q <= lraw_mem[idx_q];
			new_lw_q   <= lw_mem[idx_q];
			sat_q      <= 1'b0;
			zc_q       <= 1'b0;
		end
		// raw count times scale
		if (cmd.mul_raw) begin
			p_q    <= prod_raw;
			rneg_q <= rsel[23];
		end
		// round to q16.16
		if (cmd.rnd) begin
			r_q <= r_next;
		end
		// add offset, split into sign and magnitude
		if (cmd.sum_off) begin
			sneg_q <= s_sum[41];
			smag_q <= s_abs[40:0];
		end
		// multiplier times sum, high and low partial products
		if (cmd.gain) begin
			ph_q   <= 49'(mul_mag) * 49'(smag_q[40:24]);
			pl_q   <= 56'(mul_mag) * 56'(smag_q[23:0]);
			gneg_q <= cur_mul_q[31] ^ sneg_q;
		end
		if (cmd.wr_weight) begin
			new_lw_q   <= w_sat.val;
			new_lraw_q <= raw_q;
			sat_q      <= w_sat.sat;
		end
		if (cmd.wr_zero) begin
			new_off_q <= z_sat.val;
			sat_q     <= z_sat.sat;
		end
		if (cmd.mark_zero) begin
			zc_q <= 1'b1;
		end
		// calibration numerator
		if (cmd.cal_mul) begin
			num_q  <= 64'(mul_mag) * 64'(opv_mag);
			cneg_q <= cur_mul_q[31] ^ opv_q[31] ^ cur_lw_q[31];
		end
		if (cmd.wr_cal) begin
			new_mul_q <= c_sat.val;
			sat_q     <= c_sat.sat;
		end
		// direct writes
		if (cmd.wr_direct) begin
			case (kind_q)
				KIND_SET_OFF: begin
					new_off_q <= opv_q;
				end
				KIND_SET_MULT: begin
					new_mul_q <= opv_q;
				end
				KIND_RESET: begin
					new_off_q <= '0;
					new_mul_q <= MULT_ONE;
				end
				default: begin
				end
			endcase
		end
		// result
		if (cmd.commit) begin
			out_q.out_channel <= ch_q;
			if (inr_q) begin
				out_q.weight         <= new_lw_q;
				out_q.offset_now     <= new_off_q;
				out_q.multiplier_now <= new_mul_q;
				out_q.status         <= sat_q ? STATUS_SAT : (zc_q ? STATUS_ZERO_CAL : STATUS_OK);
			end else begin
				out_q.weight         <= '0;
				out_q.offset_now     <= '0;
				out_q.multiplier_now <= '0;
				out_q.status         <= STATUS_OK;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// status to controller
	always_comb begin
		sts.kind     = kind_q;
		sts.in_range = inr_q;
		sts.w_zero   = (cur_lw_q == 32'sd0);
		sts.div_busy = div_busy;
		sts.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== hdl/lcogc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcogc_ctrl
// Controller: sequences the datapath steps of one item by its kind, waits
// for the divider, and commits when the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lcogc_ctrl
	import lcogc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire lcogc_sts_t sts,
	output lcogc_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL_RAW,
		ST_RND,
		ST_SUM,
		ST_GAIN,
		ST_WEIGHT,
		ST_ZERO,
		ST_CAL_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CAL_WR,
		ST_DIRECT,
		ST_COMMIT
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					if (!sts.in_range) begin
						state_q <= ST_COMMIT;
					end else begin
						case (sts.kind)
							KIND_SAMPLE, KIND_ZERO:              state_q <= ST_MUL_RAW;
							KIND_CAL:                            state_q <= ST_CAL_MUL;
							KIND_SET_OFF, KIND_SET_MULT,
							KIND_RESET:                          state_q <= ST_DIRECT;
							default:                             state_q <= ST_COMMIT;
						endcase
					end
				end
				ST_MUL_RAW: state_q <= ST_RND;
				ST_RND: begin
					state_q <= (sts.kind == KIND_ZERO) ? ST_ZERO : ST_SUM;
				end
				ST_SUM:    state_q <= ST_GAIN;
				ST_GAIN:   state_q <= ST_WEIGHT;
				ST_WEIGHT: state_q <= ST_COMMIT;
				ST_ZERO:   state_q <= ST_COMMIT;
				ST_CAL_MUL: begin
					state_q <= sts.w_zero ? ST_COMMIT : ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (!sts.div_busy) state_q <= ST_CAL_WR;
				end
				ST_CAL_WR: state_q <= ST_COMMIT;
				ST_DIRECT: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd           = '0;
		in_ready      = (state_q == ST_IDLE);
		cmd.take      = in_ready && in_valid;
		cmd.fetch     = (state_q == ST_FETCH) && sts.in_range;
		cmd.mul_raw   = (state_q == ST_MUL_RAW);
		cmd.rnd       = (state_q == ST_RND);
		cmd.sum_off   = (state_q == ST_SUM);
		cmd.gain      = (state_q == ST_GAIN);
		cmd.wr_weight = (state_q == ST_WEIGHT);
		cmd.wr_zero   = (state_q == ST_ZERO);
		cmd.mark_zero = (state_q == ST_CAL_MUL) && sts.w_zero;
		cmd.cal_mul   = (state_q == ST_CAL_MUL) && !sts.w_zero;
		cmd.div_start = (state_q == ST_DIV_GO);
		cmd.wr_cal    = (state_q == ST_CAL_WR);
		cmd.wr_direct = (state_q == ST_DIRECT);
		cmd.commit    = (state_q == ST_COMMIT) && sts.out_free;
	end

endmodule

`default_nettype wire

// ===== hdl/load_cell_offset_gain_calibrator_core.sv =====
// From input transfer to result valid, each item runs the controller steps for
// its kind; a two-point cal also waits for the 32-step one-bit-per-cycle
// calibration divider.
// One item at a time; the next input is taken the cycle after the result
// is registered, even while that result waits for its output transfer.
// Reset (async, active low) restores scale, offsets 0, multipliers 1.0.
// ----------------------------------------------------------------------------
// load_cell_offset_gain_calibrator_core
// Top level: per-channel two-point offset and gain calibration engine,
// controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_offset_gain_calibrator_core
	import lcogc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire lcogc_in_t   in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output lcogc_out_t       out_data
);

	lcogc_cmd_t cmd;
	lcogc_sts_t sts;

	// controller
	lcogc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	lcogc_datapath #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

`ifndef SYNTHESIS
	// at most one datapath step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command active");

	// a commit never overwrites a result still waiting for its transfer
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// no input transfer while the divider runs
	a_div_block: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !in_ready)
		else $error("input ready during division");

	// an input transfer closes the input until the item is done
	a_take_once: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after a transfer");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the load-cell offset/gain calibrator. A queue of
// pending items feeds a clocked driver with random gaps. Every accepted item
// runs through a fixed-point model of the four channels, which queues the
// readout the block must return. A clocked monitor with random stalls
// compares each returned readout field by field. The scale register is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
	import lcogc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NUM_CH    = 4;
	localparam logic [2:0]  KIND_UNDEF = 3'd7;
	localparam longint      Q32_MAX   = 64'sd2147483647;
	localparam longint      Q32_MIN   = -64'sd2147483648;

	typedef struct {
		lcogc_in_t item;
		bit        drain;
	} send_entry_t;

	// dut signals
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	lcogc_in_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	lcogc_out_t out_data;

	// model of the channel state
	logic [31:0]        scale_q32 = SCALE_RESET;
	logic signed [31:0] ch_offset [NUM_CH];
	logic signed [31:0] ch_gain   [NUM_CH];
	logic signed [23:0] ch_raw    [NUM_CH];
	logic signed [31:0] ch_weight [NUM_CH];

	send_entry_t items_to_send[$];
	lcogc_out_t  readout_due[$];
	lcogc_out_t  readout_want;
	int          error_count = 0;
	int          send_gap = 0;
	bit          send_burst = 1'b0;
	int          sink_wait = 0;
	bit          sink_burst = 1'b0;

	load_cell_offset_gain_calibrator_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// fixed-point helpers
	// ------------------------------------------------------------------------
	function automatic longint unsigned mag64(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint apply_sign(input longint unsigned m, input bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v, inout bit hit);
		if (v > Q32_MAX) begin
			hit = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < Q32_MIN) begin
			hit = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// raw count times scale, rounded to q16.16, ties away from zero
	function automatic longint counts_to_q16(input longint raw);
		longint unsigned prod;
		longint unsigned sc;
		sc = scale_q32;
		prod = mag64(raw) * sc;
		return apply_sign((prod + 64'h8000) >> 16, raw < 0);
	endfunction

	// q8.24 gain times q16.16 value, rounded back to q16.16
	function automatic longint apply_gain(input longint gain, input longint val);
		longint unsigned mg;
		longint unsigned mv;
		longint unsigned prod;
		mg = mag64(gain);
		mv = mag64(val);
		prod = mg * (mv >> 24) + ((mg * (mv & 64'hFF_FFFF) + 64'h80_0000) >> 24);
		return apply_sign(prod, (gain < 0) != (val < 0));
	endfunction

	// one calibrator step: updates the channel state, returns the readout
	function automatic lcogc_out_t calibrate_step(input lcogc_in_t it);
		lcogc_out_t      res;
		int              ch;
		longint          raw_l;
		longint          opv_l;
		longint          gain_l;
		longint          wt_l;
		longint          sum_l;
		longint unsigned num;
		longint unsigned den;
		longint unsigned quo;
		bit              neg;
		bit              sat_hit;
		logic [1:0]      st;
		ch = it.channel;
		raw_l = $signed(it.raw_count);
		opv_l = $signed(it.operand_value);
		sat_hit = 1'b0;
		st = STATUS_OK;
		case (it.kind)
			KIND_SAMPLE: begin
				sum_l = counts_to_q16(raw_l) + longint'(ch_offset[ch]);
				ch_raw[ch] = it.raw_count;
				ch_weight[ch] = clamp32(apply_gain(ch_gain[ch], sum_l), sat_hit);
			end
			KIND_ZERO: begin
				ch_offset[ch] = clamp32(-counts_to_q16(ch_raw[ch]), sat_hit);
			end
			KIND_CAL: begin
				wt_l = ch_weight[ch];
				if (wt_l == 0) begin
					st = STATUS_ZERO_CAL;
				end else begin
					gain_l = ch_gain[ch];
					num = mag64(gain_l) * mag64(opv_l);
					den = mag64(wt_l);
					quo = (num + den / 2) / den;
					neg = ((gain_l < 0) != (opv_l < 0)) != (wt_l < 0);
					ch_gain[ch] = clamp32(apply_sign(quo, neg), sat_hit);
				end
			end
			KIND_SET_OFF: begin
				ch_offset[ch] = it.operand_value;
			end
			KIND_SET_MULT: begin
				ch_gain[ch] = it.operand_value;
			end
			KIND_RESET: begin
				ch_offset[ch] = '0;
				ch_gain[ch] = MULT_ONE;
			end
			default: begin
				// report and the undefined kind leave the state alone
			end
		endcase
		res.out_channel = it.channel;
		res.weight = ch_weight[ch];
		res.offset_now = ch_offset[ch];
		res.multiplier_now = ch_gain[ch];
		res.status = sat_hit ? STATUS_SAT : st;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// reporting
	// ------------------------------------------------------------------------
	task automatic flag_error(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_error($sformatf("%s got 0x%08h expected 0x%08h", name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// driver: presents queued items, random gap after each transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				readout_due.push_back(calibrate_step(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (items_to_send.size() == 0 ||
						(items_to_send[0].drain && readout_due.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_data <= items_to_send[0].item;
					in_valid <= 1'b1;
					void'(items_to_send.pop_front());
					if ($urandom_range(0, 39) == 0)
						send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 19);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: random stall after each transfer, checks every readout
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (readout_due.size() == 0) begin
					flag_error($sformatf("readout on channel %0d with nothing pending",
						out_data.out_channel));
				end else begin
					readout_want = readout_due.pop_front();
					compare_field("out_channel", out_data.out_channel,
						readout_want.out_channel);
					compare_field("weight", out_data.weight, readout_want.weight);
					compare_field("offset_now", out_data.offset_now,
						readout_want.offset_now);
					compare_field("multiplier_now", out_data.multiplier_now,
						readout_want.multiplier_now);
					compare_field("status", out_data.status, readout_want.status);
				end
				if ($urandom_range(0, 39) == 0)
					sink_burst = !sink_burst;
				sink_wait = sink_burst ? 0 : $urandom_range(0, 19);
			end else if (sink_wait > 0) begin
				sink_wait--;
			end
			out_ready <= (sink_wait == 0);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [2:0] k, input logic [1:0] c,
			input logic [23:0] r, input logic [31:0] v, input bit drain = 1'b0);
		send_entry_t e;
		e.item.kind = k;
		e.item.channel = c;
		e.item.raw_count = r;
		e.item.operand_value = v;
		e.drain = drain;
		items_to_send.push_back(e);
	endtask

	function automatic logic [23:0] rand_raw();
		logic [31:0] u;
		int          v;
		u = $urandom;
		case ($urandom_range(0, 9))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2, 3: begin
				v = int'($urandom_range(0, 4000)) - 2000;
				return v[23:0];
			end
			4, 5, 6: begin
				v = int'($urandom_range(0, 2097152)) - 1048576;
				return v[23:0];
			end
			default: return u[23:0];
		endcase
	endfunction

	// q8.24 gain, in half the draws close to plus or minus one
	function automatic logic [31:0] rand_gain();
		logic [31:0] u;
		int          v;
		u = $urandom;
		v = int'($urandom_range(0, 4194304)) - 2097152;
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFF00_0000 + v;
			4, 5: return u;
			default: return MULT_ONE + v;
		endcase
	endfunction

	// q16.16 offset or target weight
	function automatic logic [31:0] rand_q16();
		logic [31:0] u;
		int          v;
		u = $urandom;
		v = int'($urandom_range(0, 33554432)) - 16777216;
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return u;
			default: return v;
		endcase
	endfunction

	// mostly full calibration procedures, the rest single random items
	task automatic run_traffic(input int n_items);
		int         issued;
		logic [1:0] c;
		logic [31:0] u;
		logic [2:0] k;
		issued = 0;
		while (issued < n_items) begin
			c = $urandom_range(0, NUM_CH - 1);
			if ($urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 1) == 1) begin
					u = $urandom;
					send_item(KIND_RESET, c, rand_raw(), u);
					issued++;
				end
				u = $urandom;
				send_item(KIND_SAMPLE, c, rand_raw(), u, $urandom_range(0, 49) == 0);
				u = $urandom;
				send_item(KIND_ZERO, c, rand_raw(), u);
				u = $urandom;
				send_item(KIND_SAMPLE, c, rand_raw(), u);
				if ($urandom_range(0, 3) == 0) begin
					send_item(KIND_SET_MULT, c, rand_raw(), rand_gain());
					issued++;
				end
				send_item(KIND_CAL, c, rand_raw(), rand_q16());
				u = $urandom;
				send_item(KIND_SAMPLE, c, rand_raw(), u);
				u = $urandom;
				send_item(KIND_REPORT, c, rand_raw(), u);
				issued += 6;
			end else begin
				k = $urandom_range(0, 7);
				send_item(k, c, rand_raw(),
					($urandom_range(0, 1) == 1) ? rand_gain() : rand_q16(),
					$urandom_range(0, 49) == 0);
				issued++;
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || readout_due.size() != 0);
	endtask

	task automatic write_scale(input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		scale_q32 = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] phase_scale [7];
		logic [31:0] u;
		phase_scale[0] = SCALE_RESET;
		phase_scale[1] = 32'hFFFF_FFFF;
		phase_scale[2] = 32'h0;
		phase_scale[3] = $urandom;
		phase_scale[4] = SCALE_RESET;
		phase_scale[5] = 32'h0001_0000;
		phase_scale[6] = $urandom;
		for (int i = 0; i < NUM_CH; i++) begin
			ch_offset[i] = '0;
			ch_gain[i] = MULT_ONE;
			ch_raw[i] = '0;
			ch_weight[i] = '0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset values, zero weight cal, extremes, saturation
		send_item(KIND_REPORT, 2'd0, 24'h00_0000, 32'h0000_0000);
		send_item(KIND_CAL, 2'd1, 24'hFF_FFFF, 32'h0001_0000, 1'b1);
		send_item(KIND_SAMPLE, 2'd0, 24'h7F_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_SAMPLE, 2'd1, 24'h80_0000, 32'h0000_0000);
		send_item(KIND_ZERO, 2'd1, 24'h00_0000, 32'h0000_0000);
		send_item(KIND_SAMPLE, 2'd1, 24'h00_0000, 32'h0000_0000);
		send_item(KIND_SET_MULT, 2'd2, 24'h00_0000, 32'h7FFF_FFFF);
		send_item(KIND_SET_OFF, 2'd2, 24'h00_0000, 32'h7FFF_FFFF);
		send_item(KIND_SAMPLE, 2'd2, 24'h7F_FFFF, 32'h0000_0000);
		send_item(KIND_SET_OFF, 2'd3, 24'h00_0000, 32'h8000_0000);
		send_item(KIND_SET_MULT, 2'd3, 24'h00_0000, 32'h8000_0000);
		send_item(KIND_SAMPLE, 2'd3, 24'h80_0000, 32'h0000_0000);
		send_item(KIND_CAL, 2'd3, 24'h00_0000, 32'h7FFF_FFFF);
		send_item(KIND_CAL, 2'd0, 24'h00_0000, 32'h8000_0000);
		send_item(KIND_RESET, 2'd2, 24'h7F_FFFF, 32'hFFFF_FFFF);
		send_item(KIND_REPORT, 2'd2, 24'h80_0000, 32'h8000_0000);
		send_item(KIND_UNDEF, 2'd1, 24'hFF_FFFF, 32'h7FFF_FFFF);
		send_item(KIND_SAMPLE, 2'd0, 24'hFF_FFFF, 32'h0000_0000);
		send_item(KIND_CAL, 2'd0, 24'h00_0000, 32'h0000_0000);
		send_item(KIND_SAMPLE, 2'd0, 24'h00_0005, 32'h0000_0000);
		send_item(KIND_CAL, 2'd0, 24'h00_0000, 32'h0001_0000);
		send_item(KIND_SET_MULT, 2'd0, 24'h00_0000, 32'hFF00_0000);
		send_item(KIND_SET_OFF, 2'd0, 24'h00_0000, 32'hFFFF_0000);
		send_item(KIND_SAMPLE, 2'd0, 24'h00_0100, 32'h0000_0000);

		for (int ph = 0; ph < 7; ph++) begin
			if (ph != 0) begin
				wait_idle();
				write_scale(phase_scale[ph]);
			end
			// full scale: zero offset of the most negative reading saturates
			if (ph == 1) begin
				u = $urandom;
				send_item(KIND_SAMPLE, 2'd1, 24'h80_0000, u);
				send_item(KIND_ZERO, 2'd1, 24'h00_0000, u);
				send_item(KIND_REPORT, 2'd1, 24'h00_0000, u);
			end
			run_traffic(86);
		end

		wait_idle();
		repeat (64) @(posedge clk);
		if (error_count == 0 && readout_due.size() == 0)
			$display("[load_cell_offset_gain_calibrator_core] OK");
		else
			$display("[load_cell_offset_gain_calibrator_core] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("[load_cell_offset_gain_calibrator_core] ERROR");
		$finish;
	end

endmodule
